/* rtl/core/crc8pr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crc8pr_pkg;

    // Item kinds on the input tuser
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Receive phases
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_SIZE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CRC        = 3'd1;
    localparam logic [2:0] ST_ID         = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_TIMEOUT    = 3'd4;
    localparam logic [2:0] ST_BADLEN     = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_EXPECTED_ID   = 2'd0;
    localparam logic [1:0] REG_CONFIRM_CODE  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  CRC_POLY          = 8'h8C;
    localparam logic [7:0]  START_MARK        = 8'h23;
    localparam logic [7:0]  MIN_SIZE          = 8'd5;
    localparam logic [15:0] TIMEOUT_RESET_VAL = 16'd1000;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame_id;
        logic [7:0] frame_command;
        logic [7:0] frame_size;
        logic       is_confirm;
    } result_t;

    // Reflected CRC-8, LSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/crc8_packet_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none

// Framed packet receiver with reflected CRC-8 (poly 0x8C) check.
// Input stream (s_*): one transfer per item. s_tuser carries the kind
// (byte, tick, end of burst), s_tdata the received byte. Bytes are dropped
// until the '#' marker; then size, id, command and the rest of the frame
// follow, the CRC covering everything up to and including the check byte.
// Result stream (m_*): one status transfer per frame, per timeout, or per
// end of burst that cuts a frame short.
// Config channel (cfg_*): register index and data; always ready. Write only
// while the block is idle.
// Throughput: one item per cycle while s_tready is high. The CRC byte update,
// phase step and status decode are combinational, ahead of the state registers.
// Output: each result is registered before it appears on m_*.
// Stalls: results land in the output register; a second result while that
// one waits goes to a one-entry skid register, and s_tready drops only
// while the skid register is occupied.
// Reset (aresetn low, synchronous): receiver back to hunting, counters
// cleared, config registers to their defaults, output stream empty.
module crc8_packet_receiver
    import crc8pr_pkg::*;
#(
    parameter int TIMEOUT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] kind

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] frame_id, [15:8] frame_command,
                                        // [23:16] frame_size
    output logic [3:0]       m_tuser,   // [2:0] status, [3] is_confirm

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // width for comparing the idle count against the 16-bit limit
    localparam int CMP_W = (TIMEOUT_BITS > 16) ? TIMEOUT_BITS : 16;

    // ---------------- configuration ----------------
    logic [7:0]  expected_id_reg;
    logic [7:0]  confirm_code_reg;
    logic [15:0] timeout_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg   <= '0;
            confirm_code_reg  <= '0;
            timeout_ticks_reg <= TIMEOUT_RESET_VAL;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_EXPECTED_ID:   expected_id_reg   <= cfg_data[7:0];
                REG_CONFIRM_CODE:  confirm_code_reg  <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- receiver state ----------------
    logic [1:0]              phase_reg,         phase_next;
    logic [7:0]              bytes_seen_reg,    bytes_seen_next;
    logic [7:0]              declared_size_reg, declared_size_next;
    logic [7:0]              running_crc_reg,   running_crc_next;
    logic [7:0]              held_id_reg,       held_id_next;
    logic [7:0]              held_command_reg,  held_command_next;
    logic [TIMEOUT_BITS-1:0] idle_ticks_reg,    idle_ticks_next;
    logic                    byte_arrived_reg,  byte_arrived_next;

    logic                    in_xfer;
    logic                    res_valid;
    result_t                 res;
    logic                    rearm;
    logic [7:0]              crc_upd;
    logic [7:0]              seen_inc;
    logic [TIMEOUT_BITS-1:0] idle_inc;

    assign in_xfer  = s_tvalid && s_tready;
    assign crc_upd  = crc8_byte(running_crc_reg, s_tdata);
    assign seen_inc = bytes_seen_reg + 8'd1;
    // saturating idle count
    assign idle_inc = (&idle_ticks_reg) ? idle_ticks_reg
                                        : idle_ticks_reg + {{(TIMEOUT_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        phase_next         = phase_reg;
        bytes_seen_next    = bytes_seen_reg;
        declared_size_next = declared_size_reg;
        running_crc_next   = running_crc_reg;
        held_id_next       = held_id_reg;
        held_command_next  = held_command_reg;
        idle_ticks_next    = idle_ticks_reg;
        byte_arrived_next  = byte_arrived_reg;
        res_valid          = 1'b0;
        res                = '0;
        rearm              = 1'b0;

        unique case (s_tuser)
            KIND_TICK: begin
                if (!byte_arrived_reg) begin
                    idle_ticks_next = idle_inc;
                    if (CMP_W'(idle_inc) > CMP_W'(timeout_ticks_reg)) begin
                        res_valid  = 1'b1;
                        res.status = ST_TIMEOUT;
                        rearm      = 1'b1;
                    end
                end
            end
            KIND_END: begin
                // PH_HUNT and the unused phase code both count as hunting
                if (phase_reg == PH_SIZE || phase_reg == PH_BODY) begin
                    res_valid         = 1'b1;
                    res.status        = ST_INCOMPLETE;
                    res.frame_id      = held_id_reg;
                    res.frame_command = held_command_reg;
                    res.frame_size    = declared_size_reg;
                end
                rearm = 1'b1;
            end
            KIND_BYTE: begin
                byte_arrived_next = 1'b1;
                unique case (phase_reg)
                    PH_SIZE: begin
                        running_crc_next   = crc_upd;
                        bytes_seen_next    = seen_inc;
                        declared_size_next = s_tdata;
                        if (s_tdata < MIN_SIZE) begin
                            res_valid      = 1'b1;
                            res.status     = ST_BADLEN;
                            res.frame_size = s_tdata;
                            rearm          = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        running_crc_next = crc_upd;
                        bytes_seen_next  = seen_inc;
                        if (seen_inc == 8'd3) begin
                            held_id_next = s_tdata;
                        end else if (seen_inc == 8'd4) begin
                            held_command_next = s_tdata;
                        end
                        // last byte of the frame: the check byte
                        if (seen_inc >= declared_size_reg) begin
                            res_valid         = 1'b1;
                            res.frame_id      = held_id_next;
                            res.frame_command = held_command_next;
                            res.frame_size    = declared_size_reg;
                            rearm             = 1'b1;
                            if (crc_upd != 8'd0) begin
                                res.status = ST_CRC;
                            end else if (held_id_next != expected_id_reg) begin
                                res.status = ST_ID;
                            end else begin
                                res.status     = ST_OK;
                                res.is_confirm = (held_command_next == confirm_code_reg);
                            end
                        end
                    end
                    default: begin
                        // hunting: wait for the start marker
                        phase_next = PH_HUNT;
                        if (s_tdata == START_MARK) begin
                            running_crc_next = crc8_byte(8'd0, s_tdata);
                            bytes_seen_next  = 8'd1;
                            phase_next       = PH_SIZE;
                        end
                    end
                endcase
            end
            default: ; // unused kind: no effect
        endcase

        if (rearm) begin
            phase_next         = PH_HUNT;
            bytes_seen_next    = '0;
            declared_size_next = '0;
            running_crc_next   = '0;
            held_id_next       = '0;
            held_command_next  = '0;
            idle_ticks_next    = '0;
            byte_arrived_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            bytes_seen_reg    <= '0;
            declared_size_reg <= '0;
            running_crc_reg   <= '0;
            held_id_reg       <= '0;
            held_command_reg  <= '0;
            idle_ticks_reg    <= '0;
            byte_arrived_reg  <= 1'b0;
        end else if (in_xfer) begin
            phase_reg         <= phase_next;
            bytes_seen_reg    <= bytes_seen_next;
            declared_size_reg <= declared_size_next;
            running_crc_reg   <= running_crc_next;
            held_id_reg       <= held_id_next;
            held_command_reg  <= held_command_next;
            idle_ticks_reg    <= idle_ticks_next;
            byte_arrived_reg  <= byte_arrived_next;
        end
    end

    // ---------------- output register + skid ----------------
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    out_xfer;
    logic    emit;

    assign out_xfer = out_valid_reg && m_tready;
    assign emit     = in_xfer && res_valid;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_xfer) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (emit) begin
                if (!out_valid_reg || out_xfer) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_xfer) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_xfer) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (emit) begin
            if (!out_valid_reg || out_xfer) begin
                out_data_reg <= res;
            end else begin
                skid_data_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.frame_size, out_data_reg.frame_command,
                       out_data_reg.frame_id};
    assign m_tuser  = {out_data_reg.is_confirm, out_data_reg.status};

endmodule

`default_nettype wire
